// ===== hw/rtl/cdpt_pkg.sv =====
// Shared types and constants for the color dedup palette table.
package cdpt_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 255;

  localparam int unsigned COLOR_W  = 15;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned SLOT_W   = 8;
  localparam int unsigned CAP_W    = 8;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = 8'd255;

  localparam logic OP_REGISTER = 1'b0;
  localparam logic OP_READ     = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RD_ISSUE,
    ST_RD_WAIT,
    ST_FINISH
  } cdpt_state_t;

  typedef struct packed {
    logic start;
    logic search_step;
    logic search_end;
    logic slot_issue;
    logic slot_end;
    logic out_load;
  } cdpt_cmd_t;

  typedef struct packed {
    logic op_read;
    logic hit;
    logic miss;
    logic out_free;
  } cdpt_stat_t;

endpackage

// ===== hw/rtl/cdpt_ram.sv =====
// Generic simple dual-port RAM with registered read.
module cdpt_ram #(
  parameter int unsigned WIDTH = 15,
  parameter int unsigned DEPTH = 255,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/cdpt_ctrl.sv =====
// Controller state machine for the color dedup palette table.
module cdpt_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cdpt_pkg::cdpt_stat_t  stat,
  output cdpt_pkg::cdpt_cmd_t   cmd
);

  cdpt_pkg::cdpt_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cdpt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = (state != cdpt_pkg::ST_IDLE);
    unique case (state)
      cdpt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = stat.op_read ? cdpt_pkg::ST_RD_ISSUE : cdpt_pkg::ST_SEARCH;
        end
      end
      cdpt_pkg::ST_SEARCH: begin
        if (stat.hit || stat.miss) begin
          cmd.search_end = 1'b1;
          state_next     = cdpt_pkg::ST_FINISH;
        end else begin
          cmd.search_step = 1'b1;
        end
      end
      cdpt_pkg::ST_RD_ISSUE: begin
        cmd.slot_issue = 1'b1;
        state_next     = cdpt_pkg::ST_RD_WAIT;
      end
      cdpt_pkg::ST_RD_WAIT: begin
        cmd.slot_end = 1'b1;
        state_next   = cdpt_pkg::ST_FINISH;
      end
      cdpt_pkg::ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = cdpt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = cdpt_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result loaded while output register busy");

  a_start_from_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> (state == cdpt_pkg::ST_SEARCH || state == cdpt_pkg::ST_RD_ISSUE))
    else $error("item start did not enter a work state");

  a_search_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.search_end |=> (state == cdpt_pkg::ST_FINISH))
    else $error("search end did not reach finish");

endmodule

// ===== hw/rtl/cdpt_dp.sv =====
// Datapath: color store, search pointer, entry count, capacity and result registers.
module cdpt_dp #(
  parameter int unsigned MAX_ENTRIES = cdpt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cdpt_pkg::cdpt_cmd_t           cmd,
  output cdpt_pkg::cdpt_stat_t          stat,
  input  logic                          in_opcode,
  input  logic [cdpt_pkg::COLOR_W-1:0]  in_color,
  input  logic [cdpt_pkg::SLOT_W-1:0]   in_slot,
  input  logic                          cfg_we,
  input  logic [cdpt_pkg::CAP_W-1:0]    cfg_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_status,
  output logic [cdpt_pkg::INDEX_W-1:0]  out_index,
  output logic                          out_inserted,
  output logic [cdpt_pkg::COLOR_W-1:0]  out_word
);

  localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_ENTRIES);

  logic [cdpt_pkg::CAP_W-1:0]   capacity;
  logic [CW-1:0]                count;
  logic [CW-1:0]                ptr;
  logic                         cmp_valid;
  logic [AW-1:0]                cmp_addr;
  logic [cdpt_pkg::COLOR_W-1:0] color_q;
  logic [cdpt_pkg::SLOT_W-1:0]  slot_q;

  logic                         res_status;
  logic [cdpt_pkg::INDEX_W-1:0] res_index;
  logic                         res_inserted;
  logic [cdpt_pkg::COLOR_W-1:0] res_word;

  logic                         wr_en;
  logic                         rd_en;
  logic [AW-1:0]                rd_addr;
  logic [cdpt_pkg::COLOR_W-1:0] rd_data;
  logic [cdpt_pkg::SLOT_W-1:0]  slot_minus;
  logic                         more;
  logic                         hit;
  logic                         miss;
  logic                         full;
  logic                         slot_hit;

  assign more       = (ptr < count);
  assign hit        = cmp_valid && (rd_data == color_q);
  assign miss       = (ptr == count) && !hit;
  assign full       = (cdpt_pkg::CAP_W'(count) >= capacity) || (count == COUNT_MAX);
  assign slot_minus = slot_q - cdpt_pkg::SLOT_W'(1);
  assign slot_hit   = (slot_q != '0) && (slot_q <= cdpt_pkg::SLOT_W'(count));

  assign wr_en   = cmd.search_end && !hit && !full;
  assign rd_en   = (cmd.search_step && more) || cmd.slot_issue;
  assign rd_addr = cmd.slot_issue ? slot_minus[AW-1:0] : ptr[AW-1:0];

  assign stat.op_read  = (in_opcode == cdpt_pkg::OP_READ);
  assign stat.hit      = hit;
  assign stat.miss     = miss;
  assign stat.out_free = !out_valid || !out_stall;

  cdpt_ram #(
    .WIDTH (cdpt_pkg::COLOR_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (color_q),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= cdpt_pkg::CAPACITY_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      ptr       <= '0;
      cmp_valid <= 1'b0;
    end else begin
      if (cmd.start) begin
        ptr       <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.search_step) begin
        if (more) begin
          ptr       <= ptr + CW'(1);
          cmp_valid <= 1'b1;
        end else begin
          cmp_valid <= 1'b0;
        end
      end
      if (wr_en) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      color_q <= in_color;
      slot_q  <= in_slot;
    end
    if (cmd.search_step && more) begin
      cmp_addr <= ptr[AW-1:0];
    end
    if (cmd.search_end) begin
      res_word <= '0;
      if (hit) begin
        res_status   <= cdpt_pkg::STATUS_OK;
        res_index    <= cdpt_pkg::INDEX_W'(cmp_addr);
        res_inserted <= 1'b0;
      end else if (full) begin
        res_status   <= cdpt_pkg::STATUS_FULL;
        res_index    <= '0;
        res_inserted <= 1'b0;
      end else begin
        res_status   <= cdpt_pkg::STATUS_OK;
        res_index    <= cdpt_pkg::INDEX_W'(count);
        res_inserted <= 1'b1;
      end
    end
    if (cmd.slot_end) begin
      res_status   <= cdpt_pkg::STATUS_OK;
      res_index    <= '0;
      res_inserted <= 1'b0;
      res_word     <= slot_hit ? rd_data : '0;
    end
    if (cmd.out_load) begin
      out_status   <= res_status;
      out_index    <= res_index;
      out_inserted <= res_inserted;
      out_word     <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_MAX)
    else $error("entry count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |-> count == $past(count) + CW'(1))
    else $error("entry count moved by other than one");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (cdpt_pkg::CAP_W'(count) < capacity && count < COUNT_MAX))
    else $error("insert into a full table");

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    ptr <= count)
    else $error("search pointer past entry count");

endmodule

// ===== hw/rtl/color_dedup_palette_table_unit.sv =====
// Top level of the color dedup palette table: lookup-or-insert and palette read.
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    opcode, color, palette_slot
//   out      output     out_valid / out_stall  status, entry_index, inserted, palette_word
//   cfg      input      cfg_valid / cfg_ready  cfg_data (capacity)
//
// A register item is dispatched, then the search walks the stored colors one per cycle
// through the registered read port of the color store, and the item finishes. A palette
// read is dispatched, issued, waits and finishes. One item is worked on at a time.
// Reset (rst, synchronous) empties the table and sets capacity to 255.
// A finished result waits in the output register while out_stall is high; the next
// item is taken meanwhile and holds in its finish state until that register frees.
module color_dedup_palette_table_unit #(
  parameter int unsigned MAX_ENTRIES = cdpt_pkg::MAX_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          opcode,
  input  logic [cdpt_pkg::COLOR_W-1:0]  color,
  input  logic [cdpt_pkg::SLOT_W-1:0]   palette_slot,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          status,
  output logic [cdpt_pkg::INDEX_W-1:0]  entry_index,
  output logic                          inserted,
  output logic [cdpt_pkg::COLOR_W-1:0]  palette_word,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [cdpt_pkg::CAP_W-1:0]    cfg_data
);

  cdpt_pkg::cdpt_cmd_t  cmd;
  cdpt_pkg::cdpt_stat_t stat;

  assign cfg_ready = 1'b1;

  cdpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  cdpt_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_opcode    (opcode),
    .in_color     (color),
    .in_slot      (palette_slot),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (status),
    .out_index    (entry_index),
    .out_inserted (inserted),
    .out_word     (palette_word)
  );

endmodule
